FILE: hw/rtl/htts_pkg.sv
// Shared types and constants for the heater timer with temperature smoothing.
package htts_pkg;

  // Request kinds carried on the slave-side tuser
  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_BTN_ONE = 2'd1;
  localparam logic [1:0] REQ_BTN_TWO = 2'd2;

  // Phase codes
  localparam logic [1:0] PHASE_START   = 2'd0;
  localparam logic [1:0] PHASE_SENSORS = 2'd1;
  localparam logic [1:0] PHASE_READY   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_HOLDOFF = 2'd0;
  localparam logic [1:0] CFG_ADD_MIN = 2'd1;
  localparam logic [1:0] CFG_MAX_MIN = 2'd2;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned AVG_W     = 16;
  localparam int unsigned MIN_W     = 8;
  localparam int unsigned SEC_W     = 6;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned HOLDOFF_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 16'd500;
  localparam logic [MIN_W-1:0]     ADD_MIN_RST = 8'd10;
  localparam logic [MIN_W-1:0]     MAX_MIN_RST = 8'd90;

  localparam logic [SEC_W-1:0] SEC_MINUTE = 6'd60;
  localparam logic [SEC_W-1:0] SEC_FRESH  = 6'd62;
  localparam logic [SEC_W-1:0] SEC_STEP   = 6'd2;

  // Divide by 5: floor(x * RECIP_MUL / 2^RECIP_SHIFT) == floor(x / 5) for x < 2^18
  localparam int unsigned  MAG_W       = 18;
  localparam int unsigned  RECIP_W     = 20;
  localparam int unsigned  RECIP_SHIFT = 22;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 20'd838861;

  typedef struct packed {
    logic             heating;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
  } timer_state_t;

  typedef struct packed {
    logic [HOLDOFF_W-1:0] holdoff;
    logic [MIN_W-1:0]     add_min;
    logic [MIN_W-1:0]     max_min;
  } timer_cfg_t;

endpackage

FILE: hw/rtl/htts_smooth.sv
// One smoothing channel: load or (4*avg + 16*sample)/5, rounded and saturated.
module htts_smooth (
  input  logic                                 load_i,
  input  logic signed [htts_pkg::AVG_W-1:0]    avg_i,
  input  logic signed [htts_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [htts_pkg::AVG_W-1:0]    avg_o
);
  import htts_pkg::*;

  logic signed [18:0]         avg_x4;
  logic signed [18:0]         samp_x16;
  logic signed [18:0]         num;
  logic [18:0]                num_neg;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W-1:0]           mag_rnd;
  logic [MAG_W+RECIP_W-1:0]   prod;
  logic [AVG_W-1:0]           quo;
  logic [AVG_W-1:0]           filt;

  assign avg_x4   = {avg_i[AVG_W-1], avg_i, 2'b00};
  assign samp_x16 = {{3{sample_i[SAMPLE_W-1]}}, sample_i, 4'b0000};
  assign num      = avg_x4 + samp_x16;
  assign num_neg  = 19'(-num);
  assign mag      = num[18] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
  // +2 gives round to nearest, ties away from zero, on the magnitude
  assign mag_rnd  = mag + MAG_W'(2);
  assign prod     = {{RECIP_W{1'b0}}, mag_rnd} * {{MAG_W{1'b0}}, RECIP_MUL};
  assign quo      = prod[RECIP_SHIFT+AVG_W-1:RECIP_SHIFT];

  always_comb begin
    if (num[18]) begin
      filt = AVG_W'(-{1'b0, quo});
    end else if (quo[AVG_W-1]) begin
      filt = {1'b0, {(AVG_W-1){1'b1}}};
    end else begin
      filt = quo;
    end
  end

  assign avg_o = load_i ? {sample_i, 4'b0000} : filt;

endmodule

FILE: hw/rtl/htts_timer.sv
// Next-state logic for the countdown timer and the two debounced buttons.
module htts_timer (
  input  logic [1:0]                   req_i,
  input  logic [htts_pkg::STAMP_W-1:0] now_i,
  input  htts_pkg::timer_cfg_t         cfg_i,
  input  htts_pkg::timer_state_t       state_i,
  input  logic [htts_pkg::STAMP_W-1:0] last_one_i,
  input  logic [htts_pkg::STAMP_W-1:0] last_two_i,
  output htts_pkg::timer_state_t       state_o,
  output logic [htts_pkg::STAMP_W-1:0] last_one_o,
  output logic [htts_pkg::STAMP_W-1:0] last_two_o
);
  import htts_pkg::*;

  logic [STAMP_W-1:0] elapsed_one;
  logic [STAMP_W-1:0] elapsed_two;
  logic               ok_one;
  logic               ok_two;

  assign elapsed_one = now_i - last_one_i;
  assign elapsed_two = now_i - last_two_i;
  assign ok_one = elapsed_one > {{(STAMP_W-HOLDOFF_W){1'b0}}, cfg_i.holdoff};
  assign ok_two = elapsed_two > {{(STAMP_W-HOLDOFF_W){1'b0}}, cfg_i.holdoff};

  always_comb begin
    logic [MIN_W-1:0] m;
    logic [SEC_W-1:0] s;
    logic [MIN_W:0]   sum;
    state_o    = state_i;
    last_one_o = last_one_i;
    last_two_o = last_two_i;
    m   = state_i.minutes;
    s   = state_i.seconds;
    sum = '0;
    unique case (req_i)
      REQ_TICK: begin
        state_o.heating = |state_i.minutes;
        if ((|m) && (s == '0)) begin
          m = m - MIN_W'(1);
          s = SEC_MINUTE;
        end
        // an odd count of one second stops at zero
        s = (s >= SEC_STEP) ? s - SEC_STEP : '0;
        state_o.minutes = m;
        state_o.seconds = s;
      end
      REQ_BTN_ONE: begin
        if (ok_one) begin
          if (!state_i.heating) begin
            m = '0;
            s = SEC_FRESH;
          end
          sum = {1'b0, m} + {1'b0, cfg_i.add_min};
          state_o.minutes = (sum > {1'b0, cfg_i.max_min}) ? cfg_i.max_min : sum[MIN_W-1:0];
          state_o.seconds = s;
          last_one_o      = now_i;
        end
      end
      REQ_BTN_TWO: begin
        if (ok_two) begin
          state_o.minutes = '0;
          state_o.heating = 1'b0;
          state_o.seconds = SEC_MINUTE;
          last_two_o      = now_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/heater_timer_with_temp_smoothing_unit.sv
// Top level of the heater countdown timer with tank and solar temperature smoothing.
//
// Slave side (s_axis_*): one item per tick or button event. tuser holds the request
// kind (tick, button one, button two); tdata holds the time stamp and both samples.
// Master side (m_axis_*): exactly one result item per input item, showing the timer,
// phase and both smoothed temperatures after that item.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; always
// ready. Index 0 hold-off in ms, 1 minutes per press, 2 minute cap; others ignored.
// The user must write registers only while no item is in flight; the block does
// not enforce it. An accepted item is captured in the input register, and its result
// is loaded into the output register, raising m_axis_tvalid, once it is empty or taken.
// Throughput is one item per cycle while the receiver keeps m_axis_tready high; the
// per-item path is one 18x20 multiply for the divide by five per channel.
// Reset clears the phase, averages, timer, press stamps and both handshake stages and
// loads the register defaults (500 ms, 10 min, 90 min).
// When the receiver stalls, the result stays in the output register, one more item
// waits in the input register, and s_axis_tready drops until the output is taken.
module heater_timer_with_temp_smoothing_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: now_ms[31:0], tank_sample[43:32], solar_sample[55:44]
  input  logic [htts_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: heating_on[0], phase_code[2:1], minutes_left[10:3], seconds_left[16:11],
  //        tank_average[32:17], solar_average[48:33], zero[55:49]
  output logic [htts_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [htts_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [htts_pkg::HOLDOFF_W-1:0]       cfg_data_i
);
  import htts_pkg::*;

  // configuration
  timer_cfg_t cfg_q;

  // input stage
  logic                       in_valid_q;
  logic [1:0]                 in_req_q;
  logic [STAMP_W-1:0]         in_now_q;
  logic signed [SAMPLE_W-1:0] in_tank_q;
  logic signed [SAMPLE_W-1:0] in_solar_q;

  // block state
  logic [1:0]                 phase_q, phase_d;
  logic signed [AVG_W-1:0]    tank_avg_q, tank_avg_d;
  logic signed [AVG_W-1:0]    solar_avg_q, solar_avg_d;
  timer_state_t               timer_q, timer_d;
  logic [STAMP_W-1:0]         last_one_q, last_one_d;
  logic [STAMP_W-1:0]         last_two_q, last_two_d;

  // output stage
  logic                       out_valid_q;
  logic [OUT_DATA_W-1:0]      out_data_q, out_data_d;

  logic                       advance;
  logic                       in_fire;
  logic                       is_tick;
  logic                       avg_load;
  logic                       avg_upd;
  logic signed [AVG_W-1:0]    tank_new;
  logic signed [AVG_W-1:0]    solar_new;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign is_tick  = (in_req_q == REQ_TICK);
  assign avg_load = (phase_q == PHASE_SENSORS);
  assign avg_upd  = is_tick && ((phase_q == PHASE_SENSORS) || (phase_q == PHASE_READY));

  htts_smooth u_smooth_tank (
    .load_i   (avg_load),
    .avg_i    (tank_avg_q),
    .sample_i (in_tank_q),
    .avg_o    (tank_new)
  );

  htts_smooth u_smooth_solar (
    .load_i   (avg_load),
    .avg_i    (solar_avg_q),
    .sample_i (in_solar_q),
    .avg_o    (solar_new)
  );

  htts_timer u_timer (
    .req_i      (in_req_q),
    .now_i      (in_now_q),
    .cfg_i      (cfg_q),
    .state_i    (timer_q),
    .last_one_i (last_one_q),
    .last_two_i (last_two_q),
    .state_o    (timer_d),
    .last_one_o (last_one_d),
    .last_two_o (last_two_d)
  );

  always_comb begin
    phase_d = phase_q;
    if (is_tick) begin
      unique case (phase_q)
        PHASE_READY:   phase_d = PHASE_READY;
        PHASE_SENSORS: phase_d = PHASE_READY;
        default:       phase_d = PHASE_SENSORS; // start and the unused code
      endcase
    end
  end

  assign tank_avg_d  = avg_upd ? tank_new : tank_avg_q;
  assign solar_avg_d = avg_upd ? solar_new : solar_avg_q;

  assign out_data_d = {7'b0, solar_avg_d, tank_avg_d, timer_d.seconds, timer_d.minutes,
                       phase_d, timer_d.heating};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.holdoff <= HOLDOFF_RST;
      cfg_q.add_min <= ADD_MIN_RST;
      cfg_q.max_min <= MAX_MIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HOLDOFF: cfg_q.holdoff <= cfg_data_i;
        CFG_ADD_MIN: cfg_q.add_min <= cfg_data_i[MIN_W-1:0];
        CFG_MAX_MIN: cfg_q.max_min <= cfg_data_i[MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_req_q   <= s_axis_tuser;
      in_now_q   <= s_axis_tdata[31:0];
      in_tank_q  <= s_axis_tdata[43:32];
      in_solar_q <= s_axis_tdata[55:44];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_START;
      tank_avg_q  <= '0;
      solar_avg_q <= '0;
      timer_q     <= '0;
      last_one_q  <= '0;
      last_two_q  <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      tank_avg_q  <= tank_avg_d;
      solar_avg_q <= solar_avg_d;
      timer_q     <= timer_d;
      last_one_q  <= last_one_d;
      last_two_q  <= last_two_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
